// ===== rtl/core/wecb_pkg.sv =====
// Package for the wheel encoder edge counter and balancer.
// Item kinds, register indexes, reset values and small helper functions.
// No dependencies.
`timescale 1ns / 1ps

package wecb_pkg;

  // Item kinds carried in the input tuser
  typedef enum logic [1:0] {
    FUNC_SAMPLE     = 2'd0,
    FUNC_CTRL_TICK  = 2'd1,
    FUNC_CLR_TICKS  = 2'd2,
    FUNC_CLR_COMP   = 2'd3
  } func_t;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 3;
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_EDGE_THRESHOLD = 3'd0,
    REG_COMP_STEP      = 3'd1,
    REG_COMP_LIMIT     = 3'd2,
    REG_LEFT_SETPOINT  = 3'd3,
    REG_RIGHT_SETPOINT = 3'd4
  } reg_idx_t;

  localparam int CFG_DATA_BITS = 8;

  // Reset values
  localparam logic [7:0] EDGE_THRESHOLD_RST = 8'd10;
  localparam logic [2:0] COMP_STEP_RST      = 3'd1;
  localparam logic [6:0] COMP_LIMIT_RST     = 7'd32;

  // Direction flag bit positions
  localparam int FLAG_RIGHT_BIT = 0;
  localparam int FLAG_LEFT_BIT  = 1;

  localparam int COUNT_BITS_DEF = 16;
  localparam int TICKS_BITS     = 16;

  typedef struct packed {
    logic [7:0] ref_val;
    logic       rising;
    logic       edge_hit;
  } track_t;

  // One side of the edge detector: peak follow while rising, trough follow while falling
  function automatic track_t track(input logic [7:0] sample, input logic [7:0] ref_val,
                                   input logic rising, input logic [7:0] thr);
    track_t res;
    res.ref_val  = ref_val;
    res.rising   = rising;
    res.edge_hit = 1'b0;
    if (rising) begin
      if (ref_val < sample) begin
        res.ref_val = sample;
      end else if ((ref_val - sample) > thr) begin
        res.ref_val  = sample;
        res.rising   = 1'b0;
        res.edge_hit = 1'b1;
      end
    end else begin
      if (ref_val > sample) begin
        res.ref_val = sample;
      end else if ((sample - ref_val) > thr) begin
        res.ref_val  = sample;
        res.rising   = 1'b1;
        res.edge_hit = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic logic [7:0] add_sat(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

  function automatic logic [7:0] sub_sat(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : 8'd0;
  endfunction

endpackage

// ===== rtl/core/wheel_encoder_edge_counter_balancer_top.sv =====
// Top level of the wheel encoder edge counter and balancer.
// Depends on wecb_pkg.
//
// Takes one transaction per cycle on the in_ stream while results are taken, and returns
// exactly one registered result transaction per input on the out_ stream. A sample transaction runs
// the hysteresis edge detectors of both wheels and bumps the wrapping tick counts; a
// control tick compares left_count*right_setpoint against right_count*left_setpoint
// exactly, steps the clamped signed compensation, reports saturated drive values and
// clears both counts; the two clear kinds reset the counts or the compensation. All the
// work sits between the input handshake and a single output register, so the sustained
// rate is one transaction per clock; the output register is the only buffering, and the
// input stalls only while a held result is not taken. Configuration writes are taken at
// any time (cfg_ready is tied high) but should only land while the block is idle.
`timescale 1ns / 1ps

module wheel_encoder_edge_counter_balancer_top
  import wecb_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF   // width of the internal tick counters, 8..32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // Configuration write channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  // Input stream
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [15:0]              in_tdata,   // [7:0] left_sample, [15:8] right_sample
  input  logic [1:0]               in_tuser,   // [1:0] func
  // Result stream
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [47:0]              out_tdata,  // [15:0] left_ticks, [31:16] right_ticks,
                                               // [39:32] left_drive, [47:40] right_drive
  output logic                     out_tuser   // [0] drive_valid
);

  localparam int PROD_BITS = COUNT_BITS + 8;

  // Configuration registers
  logic [7:0] edge_thr_r;
  logic [2:0] comp_step_r;
  logic [6:0] comp_limit_r;
  logic [7:0] left_sp_r;
  logic [7:0] right_sp_r;

  // Tracking state
  logic [7:0]            left_ref_r, left_ref_nxt;
  logic [7:0]            right_ref_r, right_ref_nxt;
  logic [1:0]            rising_r, rising_nxt;
  logic [COUNT_BITS-1:0] left_cnt_r, left_cnt_nxt;
  logic [COUNT_BITS-1:0] right_cnt_r, right_cnt_nxt;
  logic signed [7:0]     comp_r, comp_nxt;

  // Output register
  logic        out_tvalid_r;
  logic [47:0] out_tdata_r, out_tdata_nxt;
  logic        out_tuser_r, out_tuser_nxt;

  logic   in_accept;
  func_t  func;
  track_t left_trk, right_trk;

  logic [PROD_BITS-1:0] left_prod, right_prod;
  logic signed [8:0]    comp_up, comp_dn, lim_pos, lim_neg;
  logic [7:0]           comp_mag;
  logic [7:0]           left_drive, right_drive;

  assign cfg_ready = 1'b1;
  // Output register frees up when empty or being drained this cycle
  assign in_tready = !out_tvalid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;
  assign func      = func_t'(in_tuser);

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // Config writes; unknown indexes fall through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_thr_r   <= EDGE_THRESHOLD_RST;
      comp_step_r  <= COMP_STEP_RST;
      comp_limit_r <= COMP_LIMIT_RST;
      left_sp_r    <= '0;
      right_sp_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_EDGE_THRESHOLD: edge_thr_r   <= cfg_data[7:0];
        REG_COMP_STEP:      comp_step_r  <= cfg_data[2:0];
        REG_COMP_LIMIT:     comp_limit_r <= cfg_data[6:0];
        REG_LEFT_SETPOINT:  left_sp_r    <= cfg_data[7:0];
        REG_RIGHT_SETPOINT: right_sp_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Edge detectors
  assign left_trk  = track(in_tdata[7:0], left_ref_r, rising_r[FLAG_LEFT_BIT], edge_thr_r);
  assign right_trk = track(in_tdata[15:8], right_ref_r, rising_r[FLAG_RIGHT_BIT], edge_thr_r);

  // Exact balance products (unsigned, so the compare gives the true sign)
  assign left_prod  = PROD_BITS'(left_cnt_r) * PROD_BITS'(right_sp_r);
  assign right_prod = PROD_BITS'(right_cnt_r) * PROD_BITS'(left_sp_r);

  // Compensation step candidates, 9 bits so the overshoot is visible before clamping
  assign comp_up = 9'(comp_r) + $signed({6'd0, comp_step_r});
  assign comp_dn = 9'(comp_r) - $signed({6'd0, comp_step_r});
  assign lim_pos = $signed({2'b00, comp_limit_r});
  assign lim_neg = -lim_pos;

  always_comb begin
    left_ref_nxt  = left_ref_r;
    right_ref_nxt = right_ref_r;
    rising_nxt    = rising_r;
    left_cnt_nxt  = left_cnt_r;
    right_cnt_nxt = right_cnt_r;
    comp_nxt      = comp_r;
    unique case (func)
      FUNC_SAMPLE: begin
        left_ref_nxt               = left_trk.ref_val;
        right_ref_nxt              = right_trk.ref_val;
        rising_nxt[FLAG_LEFT_BIT]  = left_trk.rising;
        rising_nxt[FLAG_RIGHT_BIT] = right_trk.rising;
        left_cnt_nxt  = left_cnt_r + COUNT_BITS'(left_trk.edge_hit);
        right_cnt_nxt = right_cnt_r + COUNT_BITS'(right_trk.edge_hit);
      end
      FUNC_CTRL_TICK: begin
        left_cnt_nxt  = '0;
        right_cnt_nxt = '0;
        // Clamp only on the side the step moves towards
        if (left_prod < right_prod) begin
          comp_nxt = (comp_up > lim_pos) ? lim_pos[7:0] : comp_up[7:0];
        end else if (left_prod > right_prod) begin
          comp_nxt = (comp_dn < lim_neg) ? lim_neg[7:0] : comp_dn[7:0];
        end
      end
      FUNC_CLR_TICKS: begin
        left_cnt_nxt  = '0;
        right_cnt_nxt = '0;
      end
      FUNC_CLR_COMP: begin
        comp_nxt = '0;
      end
      default: ;
    endcase
  end

  // Drive values from the updated compensation
  assign comp_mag = comp_nxt[7] ? 8'(-comp_nxt) : 8'(comp_nxt);

  always_comb begin
    if (!comp_nxt[7]) begin
      left_drive  = add_sat(left_sp_r, comp_mag);
      right_drive = sub_sat(right_sp_r, comp_mag);
    end else begin
      left_drive  = sub_sat(left_sp_r, comp_mag);
      right_drive = add_sat(right_sp_r, comp_mag);
    end
  end

  always_comb begin
    out_tuser_nxt = (func == FUNC_CTRL_TICK);
    out_tdata_nxt = {out_tuser_nxt ? right_drive : 8'd0,
                     out_tuser_nxt ? left_drive  : 8'd0,
                     TICKS_BITS'(right_cnt_nxt),
                     TICKS_BITS'(left_cnt_nxt)};
  end

  // State and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_ref_r   <= '0;
      right_ref_r  <= '0;
      rising_r     <= 2'b11;
      left_cnt_r   <= '0;
      right_cnt_r  <= '0;
      comp_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        left_ref_r   <= left_ref_nxt;
        right_ref_r  <= right_ref_nxt;
        rising_r     <= rising_nxt;
        left_cnt_r   <= left_cnt_nxt;
        right_cnt_r  <= right_cnt_nxt;
        comp_r       <= comp_nxt;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= out_tuser_nxt;
    end
  end

endmodule
